FILE: src/tcg_pkg.sv
package tcg_pkg;

    // register indexes of the configuration port
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;

    localparam logic [CfgIndexWidth-1:0] CFG_UPDATE_INTERVAL    = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_THRESHOLD_LOW      = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_THRESHOLD_MEDIUM   = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_THRESHOLD_HIGH     = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_THRESHOLD_CRITICAL = 3'd4;
    localparam logic [CfgIndexWidth-1:0] CFG_HYSTERESIS         = 3'd5;

    // configuration reset values
    localparam logic [15:0]        INTERVAL_RESET  = 16'd1000;
    localparam logic signed [11:0] THR_LOW_RESET   = 12'sd640;
    localparam logic signed [11:0] THR_MED_RESET   = 12'sd960;
    localparam logic signed [11:0] THR_HIGH_RESET  = 12'sd1200;
    localparam logic signed [11:0] THR_CRIT_RESET  = 12'sd1360;
    localparam logic [7:0]         HYST_RESET      = 8'd32;

    // operating points in MHz
    localparam logic [8:0] FREQ_MAX          = 9'd133;
    localparam logic [8:0] FREQ_BALANCED     = 9'd100;
    localparam logic [8:0] FREQ_CONSERVATIVE = 9'd75;
    localparam logic [8:0] FREQ_EMERGENCY    = 9'd48;

    // vco = 6 * f must lie in 400..1600, i.e. f in 67..266
    localparam logic [8:0] VCO_FREQ_MIN = 9'd67;
    localparam logic [8:0] VCO_FREQ_MAX = 9'd266;

    // regulator thresholds
    localparam logic [8:0] VOLT_HIGH_MHZ = 9'd120;
    localparam logic [8:0] VOLT_MED_MHZ  = 9'd80;

    typedef enum logic [1:0] {
        VOLT_1V10 = 2'd0,
        VOLT_1V15 = 2'd1,
        VOLT_1V20 = 2'd2
    } volt_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef struct packed {
        logic [15:0]        update_interval;
        logic signed [11:0] threshold_low;
        logic signed [11:0] threshold_medium;
        logic signed [11:0] threshold_high;
        logic signed [11:0] threshold_critical;
        logic [7:0]         hysteresis;
    } cfg_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] time_ms;
        logic [11:0] temperature;
        logic [8:0]  force_mhz;
    } item_t;

    typedef struct packed {
        logic        update_taken;
        logic [8:0]  frequency_mhz;
        logic [8:0]  target_mhz;
        logic        change_attempted;
        logic [1:0]  voltage_code;
        logic        change_error;
        logic        protection_active;
        logic [31:0] adjustment_count;
        logic [31:0] emergency_count;
    } result_t;

    function automatic volt_t volt_code(input logic [8:0] mhz);
        if (mhz >= VOLT_HIGH_MHZ) begin
            return VOLT_1V20;
        end
        if (mhz >= VOLT_MED_MHZ) begin
            return VOLT_1V15;
        end
        return VOLT_1V10;
    endfunction

    function automatic logic vco_ok(input logic [8:0] mhz);
        return (mhz >= VCO_FREQ_MIN) && (mhz <= VCO_FREQ_MAX);
    endfunction

endpackage

FILE: src/thermal_clock_governor.sv
// Thermal clock governor: picks a system clock frequency from die temperature.
//
// Requests come in on req_valid/req_ready with mode, time_ms, temperature and
// force_mhz. Each request produces exactly one result on rsp_valid/rsp_ready
// carrying the applied and target frequency, attempt/error flags, voltage
// code, protection flag and the two change counters.
// A request is captured in an input register, evaluated against the governor
// state by combinational compare and counter logic, and written to a result
// register; rsp_valid rises when the result register is loaded.
// Throughput is one request per cycle while the receiver takes every result;
// the state update of one request is visible to the next one.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; after that req_ready drops until the result
// is taken.
// Configuration registers are written through cfg_we/cfg_index/cfg_data with
// no wait state; write them only while no request is in flight.
// rst_n is asynchronous and active low: it empties both registers, restores
// the configuration defaults and sets the governor to 133 MHz, no direction,
// protection off and counters at zero.
module thermal_clock_governor (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [tcg_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [tcg_pkg::CfgDataWidth-1:0]  cfg_data,

    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic                              mode,
    input  logic [31:0]                       time_ms,
    input  logic signed [11:0]                temperature,
    input  logic [8:0]                        force_mhz,

    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic                              update_taken,
    output logic [8:0]                        frequency_mhz,
    output logic [8:0]                        target_mhz,
    output logic                              change_attempted,
    output logic [1:0]                        voltage_code,
    output logic                              change_error,
    output logic                              protection_active,
    output logic [31:0]                       adjustment_count,
    output logic [31:0]                       emergency_count
);
    import tcg_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t core_result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;

    // handshake control
    assign advance   = item_valid_reg && (!result_valid_reg || rsp_ready);
    assign req_ready = !item_valid_reg || advance;

    tcg_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .item   (item_reg),
        .result (core_result)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                item_valid_reg <= req_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg.mode        <= mode;
            item_reg.time_ms     <= time_ms;
            item_reg.temperature <= temperature;
            item_reg.force_mhz   <= force_mhz;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign rsp_valid         = result_valid_reg;
    assign update_taken      = result_reg.update_taken;
    assign frequency_mhz     = result_reg.frequency_mhz;
    assign target_mhz        = result_reg.target_mhz;
    assign change_attempted  = result_reg.change_attempted;
    assign voltage_code      = result_reg.voltage_code;
    assign change_error      = result_reg.change_error;
    assign protection_active = result_reg.protection_active;
    assign adjustment_count  = result_reg.adjustment_count;
    assign emergency_count   = result_reg.emergency_count;

endmodule

FILE: src/tcg_cfg_regs.sv
module tcg_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tcg_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [tcg_pkg::CfgDataWidth-1:0]  cfg_data,
    output tcg_pkg::cfg_t                    cfg
);
    import tcg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register file write decode, unknown indexes ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_UPDATE_INTERVAL:    cfg_next.update_interval    = cfg_data;
                CFG_THRESHOLD_LOW:      cfg_next.threshold_low      = cfg_data[11:0];
                CFG_THRESHOLD_MEDIUM:   cfg_next.threshold_medium   = cfg_data[11:0];
                CFG_THRESHOLD_HIGH:     cfg_next.threshold_high     = cfg_data[11:0];
                CFG_THRESHOLD_CRITICAL: cfg_next.threshold_critical = cfg_data[11:0];
                CFG_HYSTERESIS:         cfg_next.hysteresis         = cfg_data[7:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.update_interval    <= INTERVAL_RESET;
            cfg_reg.threshold_low      <= THR_LOW_RESET;
            cfg_reg.threshold_medium   <= THR_MED_RESET;
            cfg_reg.threshold_high     <= THR_HIGH_RESET;
            cfg_reg.threshold_critical <= THR_CRIT_RESET;
            cfg_reg.hysteresis         <= HYST_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/tcg_core.sv
module tcg_core (
    input  logic              clk,
    input  logic              rst_n,
    input  tcg_pkg::cfg_t     cfg,
    input  logic              step,
    input  tcg_pkg::item_t    item,
    output tcg_pkg::result_t  result
);
    import tcg_pkg::*;

    // governor state
    logic [8:0]  cur_freq_reg,  cur_freq_next;
    logic [8:0]  tgt_freq_reg,  tgt_freq_next;
    logic [31:0] last_time_reg, last_time_next;
    dir_t        dir_reg,       dir_next;
    logic        protect_reg,   protect_next;
    logic [31:0] total_reg,     total_next;
    logic [31:0] emerg_reg,     emerg_next;

    logic [31:0]        elapsed;
    logic               interval_done;
    logic signed [13:0] temp_ext;
    logic signed [13:0] hyst_ext;
    logic signed [13:0] adj_temp;
    logic [8:0]         band_freq;
    logic               band_crit;
    logic [8:0]         attempt_freq;

    // elapsed time since last acted-on update, wrapping
    assign elapsed       = item.time_ms - last_time_reg;
    assign interval_done = elapsed >= {16'd0, cfg.update_interval};

    // hysteresis shift against the last adjustment direction
    assign temp_ext = 14'($signed(item.temperature));
    assign hyst_ext = $signed({6'd0, cfg.hysteresis});

    always_comb
    begin
        case (dir_reg)
            DIR_UP:   adj_temp = temp_ext - hyst_ext;
            DIR_DOWN: adj_temp = temp_ext + hyst_ext;
            default:  adj_temp = temp_ext;
        endcase
    end

    // band selection, low and medium bands both give balanced frequency
    always_comb
    begin
        band_crit = 1'b0;
        if (adj_temp >= 14'(cfg.threshold_critical))
        begin
            band_freq = FREQ_EMERGENCY;
            band_crit = 1'b1;
        end
        else if (adj_temp >= 14'(cfg.threshold_high))
        begin
            band_freq = FREQ_CONSERVATIVE;
        end
        else if (adj_temp >= 14'(cfg.threshold_medium))
        begin
            band_freq = FREQ_BALANCED;
        end
        else if (adj_temp >= 14'(cfg.threshold_low))
        begin
            band_freq = FREQ_BALANCED;
        end
        else
        begin
            band_freq = FREQ_MAX;
        end
    end

    assign attempt_freq = item.mode ? item.force_mhz : band_freq;

    // next state and result for one request
    always_comb
    begin
        cur_freq_next  = cur_freq_reg;
        tgt_freq_next  = tgt_freq_reg;
        last_time_next = last_time_reg;
        dir_next       = dir_reg;
        protect_next   = protect_reg;
        total_next     = total_reg;
        emerg_next     = emerg_reg;

        result.update_taken     = 1'b0;
        result.change_attempted = 1'b0;
        result.voltage_code     = VOLT_1V10;
        result.change_error     = 1'b0;

        if (item.mode)
        begin
            // forced frequency
            result.update_taken = 1'b1;
            if (item.force_mhz == cur_freq_reg)
            begin
                tgt_freq_next = item.force_mhz;
            end
            else
            begin
                result.change_attempted = 1'b1;
                result.voltage_code     = volt_code(attempt_freq);
                if (vco_ok(attempt_freq))
                begin
                    cur_freq_next = attempt_freq;
                    tgt_freq_next = attempt_freq;
                end
                else
                begin
                    result.change_error = 1'b1;
                end
            end
        end
        else if (interval_done)
        begin
            // periodic update
            result.update_taken = 1'b1;
            protect_next        = band_crit;
            tgt_freq_next       = band_freq;
            last_time_next      = item.time_ms;
            if (band_freq != cur_freq_reg)
            begin
                dir_next = (band_freq > cur_freq_reg) ? DIR_UP : DIR_DOWN;
                result.change_attempted = 1'b1;
                result.voltage_code     = volt_code(attempt_freq);
                if (vco_ok(attempt_freq))
                begin
                    cur_freq_next = attempt_freq;
                    total_next    = total_reg + 32'd1;
                    if (attempt_freq == FREQ_EMERGENCY)
                    begin
                        emerg_next = emerg_reg + 32'd1;
                    end
                end
                else
                begin
                    // failed change keeps the timestamp so the next sample retries
                    result.change_error = 1'b1;
                    last_time_next      = last_time_reg;
                end
            end
        end

        result.frequency_mhz     = cur_freq_next;
        result.target_mhz        = tgt_freq_next;
        result.protection_active = protect_next;
        result.adjustment_count  = total_next;
        result.emergency_count   = emerg_next;
    end

    // state registers advance once per request passed to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_freq_reg  <= FREQ_MAX;
            tgt_freq_reg  <= FREQ_MAX;
            last_time_reg <= 32'd0;
            dir_reg       <= DIR_NONE;
            protect_reg   <= 1'b0;
            total_reg     <= 32'd0;
            emerg_reg     <= 32'd0;
        end
        else if (step)
        begin
            cur_freq_reg  <= cur_freq_next;
            tgt_freq_reg  <= tgt_freq_next;
            last_time_reg <= last_time_next;
            dir_reg       <= dir_next;
            protect_reg   <= protect_next;
            total_reg     <= total_next;
            emerg_reg     <= emerg_next;
        end
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcg_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SEG_ITEMS    = 165;
    localparam int STALL_CYCLES = 60;
    localparam int REPORT_MAX   = 10;

    // index with no register behind it, writes must be dropped
    localparam logic [CfgIndexWidth-1:0] CFG_SPARE_INDEX = 3'd7;

    // one line of the directed script: a register write or a request
    typedef struct {
        bit                       is_write;
        logic [CfgIndexWidth-1:0] reg_index;
        logic [CfgDataWidth-1:0]  reg_value;
        item_t                    stim;
        bit                       typed;
        result_t                  typed_res;
    } step_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_data;
    logic                     req_valid;
    logic                     req_ready;
    logic                     mode;
    logic [31:0]              time_ms;
    logic signed [11:0]       temperature;
    logic [8:0]               force_mhz;
    logic                     rsp_valid;
    logic                     rsp_ready;
    logic                     update_taken;
    logic [8:0]               frequency_mhz;
    logic [8:0]               target_mhz;
    logic                     change_attempted;
    logic [1:0]               voltage_code;
    logic                     change_error;
    logic                     protection_active;
    logic [31:0]              adjustment_count;
    logic [31:0]              emergency_count;

    // governor state as the testbench sees it
    cfg_t        gov_cfg;
    logic [8:0]  gov_freq;
    logic [8:0]  gov_target;
    logic [11:0] gov_last_temp;
    logic [31:0] gov_last_time;
    dir_t        gov_dir;
    logic        gov_protect;
    logic [31:0] gov_adjustments;
    logic [31:0] gov_emergencies;

    result_t pending_points[$];
    int      mismatches;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    bit      hold_req;
    int      hold_left;

    thermal_clock_governor u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .req_valid         (req_valid),
        .req_ready         (req_ready),
        .mode              (mode),
        .time_ms           (time_ms),
        .temperature       (temperature),
        .force_mhz         (force_mhz),
        .rsp_valid         (rsp_valid),
        .rsp_ready         (rsp_ready),
        .update_taken      (update_taken),
        .frequency_mhz     (frequency_mhz),
        .target_mhz        (target_mhz),
        .change_attempted  (change_attempted),
        .voltage_code      (voltage_code),
        .change_error      (change_error),
        .protection_active (protection_active),
        .adjustment_count  (adjustment_count),
        .emergency_count   (emergency_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // regulator supply needed for a given clock
    function automatic volt_t supply_for(input logic [8:0] mhz);
        if (mhz >= VOLT_HIGH_MHZ)
        begin
            return VOLT_1V20;
        end
        else if (mhz >= VOLT_MED_MHZ)
        begin
            return VOLT_1V15;
        end
        return VOLT_1V10;
    endfunction

    // pll lock range: six times the clock within 400..1600
    function automatic bit pll_locks(input logic [8:0] mhz);
        int vco;
        vco = 6 * int'(mhz);
        return (vco >= 400) && (vco <= 1600);
    endfunction

    // one governor decision for an accepted request, state updated in place
    function automatic result_t next_operating_point(input item_t it);
        result_t     r;
        logic [31:0] elapsed;
        logic [8:0]  pick;
        int          adj;
        r = '0;
        elapsed = it.time_ms - gov_last_time;
        if (it.mode)
        begin
            r.update_taken = 1'b1;
            if (it.force_mhz == gov_freq)
            begin
                gov_target = it.force_mhz;
            end
            else
            begin
                r.change_attempted = 1'b1;
                r.voltage_code = supply_for(it.force_mhz);
                if (pll_locks(it.force_mhz))
                begin
                    gov_freq = it.force_mhz;
                    gov_target = it.force_mhz;
                end
                else
                begin
                    r.change_error = 1'b1;
                end
            end
        end
        else if (elapsed >= 32'(gov_cfg.update_interval))
        begin
            r.update_taken = 1'b1;
            gov_last_temp = it.temperature;
            adj = $signed(it.temperature);
            // deadband works against the last move
            if (gov_dir == DIR_UP)
            begin
                adj = adj - int'(gov_cfg.hysteresis);
            end
            else if (gov_dir == DIR_DOWN)
            begin
                adj = adj + int'(gov_cfg.hysteresis);
            end
            gov_protect = 1'b0;
            if (adj >= int'($signed(gov_cfg.threshold_critical)))
            begin
                pick = FREQ_EMERGENCY;
                gov_protect = 1'b1;
            end
            else if (adj >= int'($signed(gov_cfg.threshold_high)))
            begin
                pick = FREQ_CONSERVATIVE;
            end
            else if (adj >= int'($signed(gov_cfg.threshold_medium)))
            begin
                pick = FREQ_BALANCED;
            end
            else if (adj >= int'($signed(gov_cfg.threshold_low)))
            begin
                // low and medium bands both land on the balanced point
                pick = FREQ_BALANCED;
            end
            else
            begin
                pick = FREQ_MAX;
            end
            gov_target = pick;
            if (pick != gov_freq)
            begin
                gov_dir = (pick > gov_freq) ? DIR_UP : DIR_DOWN;
                r.change_attempted = 1'b1;
                r.voltage_code = supply_for(pick);
                if (pll_locks(pick))
                begin
                    gov_freq = pick;
                    gov_adjustments = gov_adjustments + 32'd1;
                    if (pick == FREQ_EMERGENCY)
                    begin
                        gov_emergencies = gov_emergencies + 32'd1;
                    end
                end
                else
                begin
                    r.change_error = 1'b1;
                end
            end
            // a failed change leaves the timestamp so the next sample retries
            if (!r.change_error)
            begin
                gov_last_time = it.time_ms;
            end
        end
        r.frequency_mhz = gov_freq;
        r.target_mhz = gov_target;
        r.protection_active = gov_protect;
        r.adjustment_count = gov_adjustments;
        r.emergency_count = gov_emergencies;
        return r;
    endfunction

    function automatic step_row_t req_row(input bit m, input logic [31:0] t,
                                          input int celsius, input int mhz);
        step_row_t r;
        r.is_write = 1'b0;
        r.reg_index = CFG_UPDATE_INTERVAL;
        r.reg_value = '0;
        r.stim.mode = m;
        r.stim.time_ms = t;
        r.stim.temperature = 12'(celsius);
        r.stim.force_mhz = 9'(mhz);
        r.typed = 1'b0;
        r.typed_res = '0;
        return r;
    endfunction

    function automatic step_row_t checked_row(input bit m, input logic [31:0] t,
                                              input int celsius, input int mhz,
                                              input result_t res);
        step_row_t r;
        r = req_row(m, t, celsius, mhz);
        r.typed = 1'b1;
        r.typed_res = res;
        return r;
    endfunction

    function automatic step_row_t write_row(input logic [CfgIndexWidth-1:0] idx,
                                            input int val);
        step_row_t r;
        r = req_row(1'b0, '0, 0, 0);
        r.is_write = 1'b1;
        r.reg_index = idx;
        r.reg_value = 16'(val);
        return r;
    endfunction

    // register write, only while nothing is in flight
    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_UPDATE_INTERVAL:    gov_cfg.update_interval = val;
            CFG_THRESHOLD_LOW:      gov_cfg.threshold_low = val[11:0];
            CFG_THRESHOLD_MEDIUM:   gov_cfg.threshold_medium = val[11:0];
            CFG_THRESHOLD_HIGH:     gov_cfg.threshold_high = val[11:0];
            CFG_THRESHOLD_CRITICAL: gov_cfg.threshold_critical = val[11:0];
            CFG_HYSTERESIS:         gov_cfg.hysteresis = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // wait for every outstanding result, then let the bus idle with req_valid low
    task automatic settle();
        req_valid <= 1'b0;
        while (pending_points.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // present one request, entered and left at a falling edge
    task automatic offer(input item_t it, input bit typed, input result_t typed_res);
        result_t pred;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        mode <= it.mode;
        time_ms <= it.time_ms;
        temperature <= it.temperature;
        force_mhz <= it.force_mhz;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        pred = next_operating_point(it);
        pending_points.push_back(typed ? typed_res : pred);
        @(negedge clk);
    endtask

    // result side ready, with a long hold-off on demand
    initial
    begin
        rsp_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = STALL_CYCLES;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // compare each result with the oldest prediction
    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        string   off;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            seen = {update_taken, frequency_mhz, target_mhz, change_attempted,
                    voltage_code, change_error, protection_active,
                    adjustment_count, emergency_count};
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("%0t: result with no request pending: %p", $realtime, seen);
                end
            end
            else
            begin
                want = pending_points.pop_front();
                off = "";
                if (seen.update_taken !== want.update_taken) off = {off, " update_taken"};
                if (seen.frequency_mhz !== want.frequency_mhz) off = {off, " frequency_mhz"};
                if (seen.target_mhz !== want.target_mhz) off = {off, " target_mhz"};
                if (seen.change_attempted !== want.change_attempted)
                    off = {off, " change_attempted"};
                if (seen.voltage_code !== want.voltage_code) off = {off, " voltage_code"};
                if (seen.change_error !== want.change_error) off = {off, " change_error"};
                if (seen.protection_active !== want.protection_active)
                    off = {off, " protection_active"};
                if (seen.adjustment_count !== want.adjustment_count)
                    off = {off, " adjustment_count"};
                if (seen.emergency_count !== want.emergency_count)
                    off = {off, " emergency_count"};
                if (off != "")
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("%0t: mismatch on%s", $realtime, off);
                        $display("    expected %p", want);
                        $display("    actual   %p", seen);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        step_row_t   script[$];
        int          thr[$];
        int          corner_mhz[10];
        int          interval;
        int          hyst;
        int          celsius;
        int          roll;
        int          mhz_pick;
        logic [31:0] wall_ms;
        item_t       it;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_valid = 1'b0;
        mode = 1'b0;
        time_ms = '0;
        temperature = '0;
        force_mhz = '0;
        mismatches = 0;
        cycle_count = 0;
        hold_req = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 75;

        // governor state out of reset
        gov_cfg = '{INTERVAL_RESET, THR_LOW_RESET, THR_MED_RESET, THR_HIGH_RESET,
                    THR_CRIT_RESET, HYST_RESET};
        gov_freq = FREQ_MAX;
        gov_target = FREQ_MAX;
        gov_last_temp = 12'd400;
        gov_last_time = '0;
        gov_dir = DIR_NONE;
        gov_protect = 1'b0;
        gov_adjustments = '0;
        gov_emergencies = '0;

        corner_mhz = '{48, 75, 100, 133, 66, 67, 266, 267, 0, 511};

        // directed script under reset settings
        script.push_back(checked_row(1'b0, 32'd0, 400, 0,
            '{1'b0, FREQ_MAX, FREQ_MAX, 1'b0, VOLT_1V10, 1'b0, 1'b0, 32'd0, 32'd0}));
        script.push_back(checked_row(1'b1, 32'd0, 400, 48,
            '{1'b1, FREQ_MAX, FREQ_MAX, 1'b1, VOLT_1V10, 1'b1, 1'b0, 32'd0, 32'd0}));
        script.push_back(checked_row(1'b1, 32'd0, 400, 511,
            '{1'b1, FREQ_MAX, FREQ_MAX, 1'b1, VOLT_1V20, 1'b1, 1'b0, 32'd0, 32'd0}));
        script.push_back(checked_row(1'b1, 32'd0, 400, 133,
            '{1'b1, FREQ_MAX, FREQ_MAX, 1'b0, VOLT_1V10, 1'b0, 1'b0, 32'd0, 32'd0}));
        script.push_back(checked_row(1'b1, 32'd0, 400, 0,
            '{1'b1, FREQ_MAX, FREQ_MAX, 1'b1, VOLT_1V10, 1'b1, 1'b0, 32'd0, 32'd0}));
        script.push_back(checked_row(1'b0, 32'd999, 400, 0,
            '{1'b0, FREQ_MAX, FREQ_MAX, 1'b0, VOLT_1V10, 1'b0, 1'b0, 32'd0, 32'd0}));
        script.push_back(checked_row(1'b0, 32'd1000, 700, 0,
            '{1'b1, FREQ_BALANCED, FREQ_BALANCED, 1'b1, VOLT_1V15, 1'b0, 1'b0,
              32'd1, 32'd0}));
        script.push_back(req_row(1'b0, 32'd2000, 1250, 0));
        // emergency band fails the lock range, then retries on the next sample
        script.push_back(req_row(1'b0, 32'd3000, 1400, 0));
        script.push_back(req_row(1'b0, 32'd3001, 1400, 0));
        script.push_back(req_row(1'b0, 32'd4000, -1024, 0));
        // hysteresis keeps the max clock just above the low threshold
        script.push_back(req_row(1'b0, 32'd5000, 660, 0));
        script.push_back(req_row(1'b0, 32'd6000, 2047, 511));
        script.push_back(req_row(1'b1, 32'd6000, 0, 67));
        script.push_back(req_row(1'b1, 32'd6000, 0, 266));
        script.push_back(req_row(1'b1, 32'd6000, 0, 267));
        script.push_back(req_row(1'b1, 32'd6000, 0, 66));
        script.push_back(req_row(1'b0, 32'hFFFF_FFFF, 960, 0));
        script.push_back(write_row(CFG_UPDATE_INTERVAL, 0));
        // time wrapped backwards, zero interval still acts
        script.push_back(req_row(1'b0, 32'd5, 960, 0));
        script.push_back(write_row(CFG_HYSTERESIS, 255));
        script.push_back(req_row(1'b0, 32'd5, 1000, 0));
        script.push_back(req_row(1'b1, 32'd5, -1, 75));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].is_write)
            begin
                settle();
                write_reg(script[i].reg_index, script[i].reg_value);
            end
            else
            begin
                offer(script[i].stim, script[i].typed, script[i].typed_res);
            end
        end

        // random segments, each with its own settings; the idle pattern changes every two segments
        wall_ms = 32'd5;
        for (int seg = 0; seg < 6; seg++)
        begin
            thr.delete();
            repeat (4) thr.push_back(int'($urandom_range(0, 3071)) - 1024);
            if (seg != 3)
            begin
                thr.sort();
            end
            interval = $urandom_range(1, 200);
            hyst = $urandom_range(0, 255);
            case (seg)
                1:
                begin
                    interval = 65535;
                    hyst = 255;
                    thr = '{-1024, -1024, 2047, 2047};
                end
                2:
                begin
                    interval = 0;
                    hyst = 0;
                end
                3: interval = $urandom_range(0, 1000);
                4:
                begin
                    interval = 10;
                    thr = '{-1024, -1024, -1024, -1024};
                end
                5:
                begin
                    interval = int'(INTERVAL_RESET);
                    hyst = int'(HYST_RESET);
                    thr = '{int'(THR_LOW_RESET), int'(THR_MED_RESET),
                            int'(THR_HIGH_RESET), int'(THR_CRIT_RESET)};
                end
                default: ;
            endcase
            settle();
            write_reg(CFG_UPDATE_INTERVAL, 16'(interval));
            write_reg(CFG_THRESHOLD_LOW, 16'(thr[0]));
            write_reg(CFG_THRESHOLD_MEDIUM, 16'(thr[1]));
            write_reg(CFG_THRESHOLD_HIGH, 16'(thr[2]));
            write_reg(CFG_THRESHOLD_CRITICAL, 16'(thr[3]));
            write_reg(CFG_HYSTERESIS, 16'(hyst));
            write_reg(CFG_SPARE_INDEX, 16'($urandom()));

            if (seg < 2)
            begin
                send_idle_pct = 28;
                recv_idle_pct = 75;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 28;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                // long result stall so requests back up
                if ((seg == 0 || seg == 4) && n == 10)
                begin
                    hold_req = 1'b1;
                end

                // mostly a clock that moves forward around the interval
                roll = $urandom_range(0, 99);
                if (roll < 80)
                begin
                    wall_ms = wall_ms
                        + $urandom_range(0, 2 * int'(gov_cfg.update_interval) + 2);
                end
                else if (roll < 90)
                begin
                    wall_ms = $urandom();
                end
                else
                begin
                    wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
                end

                // temperatures clustered around the band edges
                if ($urandom_range(0, 99) < 60)
                begin
                    case ($urandom_range(0, 3))
                        0: celsius = $signed(gov_cfg.threshold_low);
                        1: celsius = $signed(gov_cfg.threshold_medium);
                        2: celsius = $signed(gov_cfg.threshold_high);
                        default: celsius = $signed(gov_cfg.threshold_critical);
                    endcase
                    celsius = celsius
                        + int'($urandom_range(0, 2 * int'(gov_cfg.hysteresis) + 80))
                        - (int'(gov_cfg.hysteresis) + 40);
                    if (celsius < -1024)
                    begin
                        celsius = -1024;
                    end
                    if (celsius > 2047)
                    begin
                        celsius = 2047;
                    end
                end
                else
                begin
                    celsius = int'($urandom_range(0, 3071)) - 1024;
                end

                if ($urandom_range(0, 1) == 0)
                begin
                    mhz_pick = corner_mhz[$urandom_range(0, 9)];
                end
                else
                begin
                    mhz_pick = $urandom_range(0, 511);
                end

                it.mode = ($urandom_range(0, 3) == 0);
                it.time_ms = wall_ms;
                it.temperature = 12'(celsius);
                it.force_mhz = 9'(mhz_pick);
                offer(it, 1'b0, '0);
            end
        end

        // drain and finish
        req_valid <= 1'b0;
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_points.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
